@@ sv/lzss_window_decompressor_defines.svh @@
// Assertion macros used by the LZSS window decompressor checker.
// No dependencies; included by the checker file.
`ifndef LZSS_WINDOW_DECOMPRESSOR_DEFINES_SVH
`define LZSS_WINDOW_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZWD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lzwd_pkg.sv @@
// Types and constants of the LZSS window decompressor.
// No dependencies; used by the decompressor, its output queue and the checker.
`default_nettype none

package lzwd_pkg;

  localparam int WIN_AW       = 12;
  localparam int WINDOW_DEPTH = 1 << WIN_AW;
  localparam int FILL_W       = WIN_AW + 1;
  localparam int LEN_W        = 5;
  localparam int LEN_BIAS     = 3;

  localparam logic [WIN_AW-1:0] WIN_START = 12'd4078;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN  = 1'b1;

  // parse phase codes; the unused code behaves as PH_TOKEN
  localparam logic [1:0] PH_TOKEN    = 2'd0;
  localparam logic [1:0] PH_FIRST    = 2'd1;
  localparam logic [1:0] PH_MATCH_HI = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COPY
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } code_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
    logic       length_ok;
  } result_t;

endpackage

`default_nettype wire

@@ sv/lzwd_stream_if.sv @@
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is a parameter; used with lzwd_pkg types.
`default_nettype none

interface lzwd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/lzwd_out_fifo.sv @@
// Two-entry result queue in front of the output channel.
// Depends on lzwd_pkg for result_t.
`default_nettype none

module lzwd_out_fifo
  import lzwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  input  logic       out_ready,
  output logic       out_valid,
  output result_t    out_data,
  output logic [1:0] count
);

  result_t entries [2];
  logic    wr_ptr;
  logic    rd_ptr;
  logic    pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/lzss_window_decompressor.sv @@
// LZSS decoder, 4 KiB window. Each input byte is taken in idle and decoded; a literal
// is queued and written to the window, and a match high byte starts a copy of its length
// nibble plus LEN_BIAS bytes, each read from the window memory, then queued and stored;
// copy runs at one byte per cycle while the output is taken.
// Reset (sync, active high) clears control state at once; no clearing pass: window
// entries not yet written read as zero through a fill count.
`default_nettype none

module lzss_window_decompressor
  import lzwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  lzwd_stream_if.sink           code,
  lzwd_stream_if.source         result
);

  // configuration
  logic [7:0]  xor_key;
  logic [31:0] expected_length;

  // sequencer
  state_t state, state_next;

  // current input byte, already descrambled
  logic [7:0] cur_byte, cur_byte_next;
  logic       cur_last, cur_last_next;

  // parser state
  logic [8:0]  flag_shift, flag_shift_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic [7:0]  match_low, match_low_next;
  logic [31:0] produced, produced_next;
  logic        finished, finished_next;

  // window bookkeeping: write pointer and how many entries hold real data
  logic [WIN_AW-1:0] wr_pos;
  logic [FILL_W-1:0] fill;

  // match copy
  logic [WIN_AW-1:0] copy_pos, copy_pos_next;
  logic [LEN_W-1:0]  copy_left, copy_left_next;

  // window memory, one write and one registered read per cycle
  logic [7:0]        window [WINDOW_DEPTH];
  logic [7:0]        ram_q;
  logic              win_we;
  logic [7:0]        win_wdata;
  logic              rd_issue;

  // read-in-flight stage: metadata travels alongside the memory read
  logic       rd_valid;
  logic       rd_fwd, rd_fwd_next;
  logic [7:0] rd_fwd_byte, rd_fwd_byte_next;
  logic       rd_hit, rd_hit_next;
  logic       rd_run_last, rd_run_last_next;
  logic       rd_done, rd_done_next;
  logic       rd_ok, rd_ok_next;
  logic [7:0] arr_byte;

  // output queue
  logic       push;
  result_t    push_data;
  logic [1:0] fifo_count;
  logic       pop;
  logic       can_push;
  logic [2:0] occ;

  // decode helpers
  logic [31:0]       produced_inc;
  logic              token;
  logic              tok_bit;
  logic              is_final;
  logic              done_c;
  logic [WIN_AW-1:0] win_off;

  lzwd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_data  (result.data),
    .count     (fifo_count)
  );

  assign pop      = result.valid && result.ready;
  assign can_push = (fifo_count != 2'd2) || pop;
  // queue occupancy once this cycle's arrival and pop settle
  assign occ      = 3'(fifo_count) + 3'(rd_valid) - 3'(pop);

  // byte from memory: forwarded if written the cycle the read went out,
  // zero if the entry was never written
  assign arr_byte = rd_fwd ? rd_fwd_byte : (rd_hit ? ram_q : 8'h00);

  assign produced_inc = produced + 32'd1;
  assign win_off      = copy_pos - WIN_START;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key         <= 8'h00;
      expected_length <= 32'd0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_XOR_KEY: xor_key         <= wr_data[7:0];
        CFG_EXP_LEN: expected_length <= wr_data;
        default:     xor_key         <= xor_key;
      endcase
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (win_we) begin
      window[wr_pos] <= win_wdata;
    end
    if (rd_issue) begin
      ram_q <= window[copy_pos];
    end
  end

  // next state and outputs
  always_comb begin
    state_next       = state;
    cur_byte_next    = cur_byte;
    cur_last_next    = cur_last;
    flag_shift_next  = flag_shift;
    parse_phase_next = parse_phase;
    match_low_next   = match_low;
    produced_next    = produced;
    finished_next    = finished;
    copy_pos_next    = copy_pos;
    copy_left_next   = copy_left;
    rd_issue         = 1'b0;
    rd_fwd_next      = rd_valid && (copy_pos == wr_pos);
    rd_fwd_byte_next = arr_byte;
    rd_hit_next      = {1'b0, win_off} < fill;
    rd_run_last_next = 1'b0;
    rd_done_next     = 1'b0;
    rd_ok_next       = 1'b0;
    code.ready       = 1'b0;
    push             = 1'b0;
    push_data        = '0;
    win_we           = 1'b0;
    win_wdata        = arr_byte;
    token            = 1'b0;
    tok_bit          = 1'b0;
    is_final         = 1'b0;
    done_c           = 1'b0;

    // a copied byte lands: queue it and store it in the window
    if (rd_valid) begin
      push                  = 1'b1;
      push_data.out_byte    = arr_byte;
      push_data.byte_valid  = 1'b1;
      push_data.run_last    = rd_run_last;
      push_data.stream_done = rd_done;
      push_data.length_ok   = rd_ok;
      win_we                = 1'b1;
    end

    case (state)
      ST_IDLE: begin
        code.ready = !rd_valid;
        if (code.valid && !rd_valid) begin
          cur_byte_next = code.data.in_byte ^ xor_key;
          cur_last_next = code.data.in_last;
          state_next    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (finished) begin
          // stream over: input is swallowed
          state_next = ST_IDLE;
        end else if (can_push) begin
          state_next = ST_IDLE;
          if (produced >= expected_length) begin
            // length already met (or lowered): status-only close
            push                  = 1'b1;
            push_data.run_last    = 1'b1;
            push_data.stream_done = 1'b1;
            push_data.length_ok   = (produced == expected_length);
            finished_next         = 1'b1;
          end else if (parse_phase == PH_MATCH_HI) begin
            copy_pos_next    = {cur_byte[7:4], match_low};
            copy_left_next   = LEN_W'(cur_byte[3:0]) + LEN_W'(LEN_BIAS);
            parse_phase_next = PH_TOKEN;
            state_next       = ST_COPY;
          end else begin
            case (parse_phase)
              PH_FIRST: begin
                token   = 1'b1;
                tok_bit = flag_shift[0];
              end
              default: begin
                if (flag_shift[8:1] <= 8'd1) begin
                  // control bits used up: this byte is a new flag byte
                  flag_shift_next  = {1'b1, cur_byte};
                  parse_phase_next = PH_FIRST;
                end else begin
                  flag_shift_next = {1'b0, flag_shift[8:1]};
                  token           = 1'b1;
                  tok_bit         = flag_shift[1];
                end
              end
            endcase

            if (token && tok_bit) begin
              // literal
              push                  = 1'b1;
              push_data.out_byte    = cur_byte;
              push_data.byte_valid  = 1'b1;
              push_data.run_last    = 1'b1;
              push_data.stream_done = cur_last || (produced_inc == expected_length);
              push_data.length_ok   = (produced_inc == expected_length);
              win_we                = 1'b1;
              win_wdata             = cur_byte;
              produced_next         = produced_inc;
              parse_phase_next      = PH_TOKEN;
              finished_next         = push_data.stream_done;
            end else begin
              if (token) begin
                match_low_next   = cur_byte;
                parse_phase_next = PH_MATCH_HI;
              end
              // stream ended mid-token: close with a status result
              if (cur_last) begin
                push                  = 1'b1;
                push_data.run_last    = 1'b1;
                push_data.stream_done = 1'b1;
                push_data.length_ok   = (produced == expected_length);
                finished_next         = 1'b1;
              end
            end
          end
        end
      end

      ST_COPY: begin
        // issue a read only if the queue can take its byte next cycle
        if (occ <= 3'd1) begin
          rd_issue       = 1'b1;
          produced_next  = produced_inc;
          copy_pos_next  = copy_pos + WIN_AW'(1);
          copy_left_next = copy_left - LEN_W'(1);
          is_final = (copy_left == LEN_W'(1)) || (produced_inc == expected_length);
          done_c   = is_final && (cur_last || (produced_inc == expected_length));
          rd_run_last_next = is_final;
          rd_done_next     = done_c;
          rd_ok_next       = done_c && (produced_inc == expected_length);
          if (is_final) begin
            state_next    = ST_IDLE;
            finished_next = done_c;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_shift  <= 9'd0;
      parse_phase <= PH_TOKEN;
      match_low   <= 8'h00;
      produced    <= 32'd0;
      finished    <= 1'b0;
      wr_pos      <= WIN_START;
      fill        <= '0;
      rd_valid    <= 1'b0;
    end else begin
      flag_shift  <= flag_shift_next;
      parse_phase <= parse_phase_next;
      match_low   <= match_low_next;
      produced    <= produced_next;
      finished    <= finished_next;
      rd_valid    <= rd_issue;
      if (win_we) begin
        wr_pos <= wr_pos + WIN_AW'(1);
        if (fill != FILL_W'(WINDOW_DEPTH)) begin
          fill <= fill + FILL_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_byte    <= cur_byte_next;
    cur_last    <= cur_last_next;
    copy_pos    <= copy_pos_next;
    copy_left   <= copy_left_next;
    rd_fwd      <= rd_fwd_next;
    rd_fwd_byte <= rd_fwd_byte_next;
    rd_hit      <= rd_hit_next;
    rd_run_last <= rd_run_last_next;
    rd_done     <= rd_done_next;
    rd_ok       <= rd_ok_next;
  end

endmodule

`default_nettype wire

@@ sv/lzwd_checker.sv @@
// Port-level checks for the LZSS window decompressor, bound to the top level.
// Depends on lzwd_pkg and lzss_window_decompressor_defines.svh.
`default_nettype none

`include "lzss_window_decompressor_defines.svh"

module lzwd_checker
  import lzwd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  logic seen_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_done <= 1'b0;
    end else if (res_valid && res_ready && res_data.stream_done) begin
      seen_done <= 1'b1;
    end
  end

  `LZWD_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready,
                    res_valid && $stable(res_data), "stalled result changed")

  `LZWD_ASSERT_NOW(a_after_done, clk, rst, res_valid, !seen_done,
                   "result after stream end")

  `LZWD_ASSERT_NOW(a_done_last, clk, rst, res_valid && res_data.stream_done,
                   res_data.run_last, "stream end not on last result of byte")

  `LZWD_ASSERT_NOW(a_status, clk, rst, res_valid && !res_data.byte_valid,
                   res_data.out_byte == 8'h00 && res_data.stream_done,
                   "status-only result malformed")

  `LZWD_ASSERT_NOW(a_ok_done, clk, rst, res_valid && res_data.length_ok,
                   res_data.stream_done, "length_ok without stream end")

endmodule

bind lzss_window_decompressor lzwd_checker u_lzwd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

`default_nettype wire
